// ===== hw/rtl/ipv4_prefix_whitelist_match_macros.svh =====
// Assertion helpers shared by the whitelist RTL.
// Both expect clk_i and rst_ni in the enclosing scope.
`ifndef IPV4_PREFIX_WHITELIST_MATCH_MACROS_SVH
`define IPV4_PREFIX_WHITELIST_MATCH_MACROS_SVH

// Property checked on every rising clock edge, off while in reset.
`define IPWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold.
`define IPWL_ASSERT_NEVER(lbl, cond, msg) \
  `IPWL_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/ipwl_pkg.sv =====
package ipwl_pkg;

  // Table depth and derived widths
  localparam int unsigned MaxEntries = 8;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned PrefixW = 6;
  localparam int unsigned HeldW   = 4;

  // Longest meaningful prefix: exact host match
  localparam logic [PrefixW-1:0] PrefixMax = PrefixW'(AddrW);

  // Function codes
  typedef enum logic [1:0] {
    FnCheck  = 2'd0,
    FnAppend = 2'd1,
    FnClear  = 2'd2,
    FnNop    = 2'd3
  } func_e;

  // Input transaction
  typedef struct packed {
    func_e              func;
    logic [AddrW-1:0]   address;
    logic [PrefixW-1:0] prefix_len;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic             allowed;
    logic             status;
    logic [HeldW-1:0] entries_held;
  } out_item_t;

  // One whitelist entry
  typedef struct packed {
    logic [AddrW-1:0]   network;
    logic [PrefixW-1:0] prefix;
  } entry_t;

  // Registered table read, tagged for the compare unit
  typedef struct packed {
    logic   vld;
    logic   last;
    entry_t entry;
  } rd_t;

  // Registered compare result
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } cmp_res_t;

  // Entry count reported in HeldW bits (masked)
  function automatic logic [HeldW-1:0] held_bits(input logic [CntW-1:0] cnt);
    logic [CntW+HeldW-1:0] ext;
    ext = {{HeldW{1'b0}}, cnt};
    return ext[HeldW-1:0];
  endfunction

endpackage

// ===== hw/rtl/ipwl_table.sv =====
module ipwl_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [ipwl_pkg::IdxW-1:0]  wr_idx_i,
  input  ipwl_pkg::entry_t           wr_entry_i,
  input  logic                       rd_en_i,
  input  logic [ipwl_pkg::IdxW-1:0]  rd_idx_i,
  input  logic                       rd_last_i,
  output ipwl_pkg::rd_t              rd_o
);

  ipwl_pkg::entry_t mem [ipwl_pkg::MaxEntries];
  ipwl_pkg::entry_t rdata_q;
  logic             rvld_q;
  logic             rlast_q;

  // Entry storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_idx_i];
    end
  end

  // Read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q  <= 1'b0;
      rlast_q <= 1'b0;
    end else begin
      rvld_q  <= rd_en_i;
      rlast_q <= rd_en_i & rd_last_i;
    end
  end

  assign rd_o.vld   = rvld_q;
  assign rd_o.last  = rlast_q;
  assign rd_o.entry = rdata_q;

endmodule

// ===== hw/rtl/ipwl_cmp.sv =====
module ipwl_cmp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ipwl_pkg::AddrW-1:0]  addr_i,
  input  ipwl_pkg::rd_t               rd_i,
  output ipwl_pkg::cmp_res_t          res_o
);

  logic [ipwl_pkg::AddrW-1:0]   mask;
  logic [ipwl_pkg::PrefixW-1:0] shamt;
  logic                         hit;
  ipwl_pkg::cmp_res_t           res_q;

  // Prefix mask: prefix 0 keeps no bits
  always_comb begin
    shamt = ipwl_pkg::PrefixMax - rd_i.entry.prefix;
    if (rd_i.entry.prefix == '0) begin
      mask = '0;
    end else begin
      mask = {ipwl_pkg::AddrW{1'b1}} << shamt;
    end
    hit = ((addr_i ^ rd_i.entry.network) & mask) == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q.vld  <= rd_i.vld;
      res_q.last <= rd_i.last;
      res_q.hit  <= hit;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/ipv4_prefix_whitelist_match.sv =====
// IPv4 prefix whitelist: holds up to ipwl_pkg::MaxEntries (network, prefix) entries.
// func check answers allowed when the list is empty or any entry matches the
// address in its leading prefix bits; append adds one entry (status 1 and no
// change when the table is full; prefixes above 32 are stored as 32); clear
// empties the list. Every transaction gives exactly one result carrying the
// count after it. Input is taken only while idle. Append, clear, an unused code
// and a check on an empty list go from idle straight to the result state; a
// check on a non-empty list first walks the table, comparing its entries.
// The walk stops on the first match; its speed is set by the single table
// read port and the one shared mask-and-compare unit, one entry per cycle.
// A waiting output stall holds the block in its result state.
`include "ipv4_prefix_whitelist_match_macros.svh"

module ipv4_prefix_whitelist_match (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ipwl_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ipwl_pkg::out_item_t  out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  logic [ipwl_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [ipwl_pkg::CntW-1:0]     rd_cnt_q, rd_cnt_d;
  logic [ipwl_pkg::AddrW-1:0]    addr_q, addr_d;
  logic                          res_allowed_q, res_allowed_d;
  logic                          res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  ipwl_pkg::out_item_t           out_data_q, out_data_d;

  logic                          in_acc;
  logic                          issue;
  logic                          rd_last;
  logic                          wr_en;
  ipwl_pkg::entry_t              wr_entry;
  ipwl_pkg::rd_t                 rd;
  ipwl_pkg::rd_t                 cmp_in;
  ipwl_pkg::cmp_res_t            cmp_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  // Table walk: one read per cycle until the count is reached
  assign issue   = (state_q == S_WALK) && (rd_cnt_q < cnt_q);
  assign rd_last = (rd_cnt_q + ipwl_pkg::CntW'(1)) == cnt_q;

  // Append write, prefix saturated to a host match
  assign wr_entry.network = in_data_i.address;
  assign wr_entry.prefix  = (in_data_i.prefix_len > ipwl_pkg::PrefixMax) ?
                            ipwl_pkg::PrefixMax : in_data_i.prefix_len;
  assign wr_en = in_acc && (in_data_i.func == ipwl_pkg::FnAppend) &&
                 (cnt_q < ipwl_pkg::CntW'(ipwl_pkg::MaxEntries));

  ipwl_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (cnt_q[ipwl_pkg::IdxW-1:0]),
    .wr_entry_i (wr_entry),
    .rd_en_i    (issue),
    .rd_idx_i   (rd_cnt_q[ipwl_pkg::IdxW-1:0]),
    .rd_last_i  (rd_last),
    .rd_o       (rd)
  );

  // Reads still in flight after a walk ends are dropped here
  always_comb begin
    cmp_in     = rd;
    cmp_in.vld = rd.vld && (state_q == S_WALK);
  end

  ipwl_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (addr_q),
    .rd_i   (cmp_in),
    .res_o  (cmp_res)
  );

  // Sequencer next state
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rd_cnt_d      = rd_cnt_q;
    addr_d        = addr_q;
    res_allowed_d = res_allowed_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_allowed_d = 1'b0;
          res_status_d  = 1'b0;
          state_d       = S_DONE;
          case (in_data_i.func)
            ipwl_pkg::FnCheck: begin
              addr_d   = in_data_i.address;
              rd_cnt_d = '0;
              if (cnt_q == '0) begin
                res_allowed_d = 1'b1;
              end else begin
                state_d = S_WALK;
              end
            end
            ipwl_pkg::FnAppend: begin
              if (cnt_q < ipwl_pkg::CntW'(ipwl_pkg::MaxEntries)) begin
                cnt_d = cnt_q + ipwl_pkg::CntW'(1);
              end else begin
                res_status_d = 1'b1;
              end
            end
            ipwl_pkg::FnClear: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + ipwl_pkg::CntW'(1);
        end
        if (cmp_res.vld && (cmp_res.hit || cmp_res.last)) begin
          res_allowed_d = cmp_res.hit;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_data_d.allowed      = res_allowed_q;
          out_data_d.status       = res_status_q;
          out_data_d.entries_held = ipwl_pkg::held_bits(cnt_q);
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      rd_cnt_q      <= '0;
      addr_q        <= '0;
      res_allowed_q <= 1'b0;
      res_status_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      rd_cnt_q      <= rd_cnt_d;
      addr_q        <= addr_d;
      res_allowed_q <= res_allowed_d;
      res_status_q  <= res_status_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `IPWL_ASSERT_NEVER(a_cnt_range, cnt_q > ipwl_pkg::CntW'(ipwl_pkg::MaxEntries), "entry count above table depth")
  `IPWL_ASSERT_NEVER(a_rd_in_range, issue && (rd_cnt_q >= cnt_q), "table read beyond held entries")
  `IPWL_ASSERT(a_full_keeps_cnt, (in_acc && (in_data_i.func == ipwl_pkg::FnAppend) && (cnt_q == ipwl_pkg::CntW'(ipwl_pkg::MaxEntries))) |=> ($stable(cnt_q) && res_status_q), "full append changed the count")
  `IPWL_ASSERT(a_empty_allows, (in_acc && (in_data_i.func == ipwl_pkg::FnCheck) && (cnt_q == '0)) |=> ((state_q == S_DONE) && res_allowed_q), "empty list must allow")
  `IPWL_ASSERT_NEVER(a_walk_nonempty, (state_q == S_WALK) && (cnt_q == '0), "walk over an empty table")

endmodule

// ===== dv/ipwl_result_checker.sv =====
`timescale 1ns / 1ps

module ipwl_result_checker
  import ipwl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        mismatch_cnt_o,
  output int        pending_o
);

  // Shadow copy of the whitelist table
  logic [AddrW-1:0]   wl_network [MaxEntries];
  logic [PrefixW-1:0] wl_prefix  [MaxEntries];
  int unsigned        wl_count;

  // Verdicts waiting for their output transaction
  out_item_t verdict_q[$];

  // Leading-ones mask for a (saturated) prefix length
  function automatic logic [AddrW-1:0] net_mask(input logic [PrefixW-1:0] plen);
    if (plen == '0) return '0;
    if (plen >= PrefixMax) return '1;
    return {AddrW{1'b1}} << (AddrW - plen);
  endfunction

  // Apply one transaction to the shadow table and return the expected result
  function automatic out_item_t whitelist_verdict(input in_item_t it);
    out_item_t res;
    logic [PrefixW-1:0] plen;
    res = '0;
    case (it.func)
      FnCheck: begin
        res.allowed = (wl_count == 0);
        for (int i = 0; i < wl_count; i++) begin
          if (((it.address ^ wl_network[i]) & net_mask(wl_prefix[i])) == '0)
            res.allowed = 1'b1;
        end
      end
      FnAppend: begin
        if (wl_count >= MaxEntries) begin
          res.status = 1'b1;
        end else begin
          plen = (it.prefix_len > PrefixMax) ? PrefixMax : it.prefix_len;
          wl_network[wl_count] = it.address;
          wl_prefix[wl_count]  = plen;
          wl_count++;
        end
      end
      FnClear: begin
        wl_count = 0;
      end
      default: ;
    endcase
    res.entries_held = HeldW'(wl_count);
    return res;
  endfunction

  // Output side is handled first: a result at the same edge belongs to an older item
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      wl_count = 0;
      verdict_q.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%0t: unexpected result allowed=%0b status=%0b held=%0d", $realtime,
                     out_data_i.allowed, out_data_i.status, out_data_i.entries_held);
        end else begin
          want = verdict_q.pop_front();
          if (want.allowed !== out_data_i.allowed || want.status !== out_data_i.status ||
              want.entries_held !== out_data_i.entries_held) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("%0t: mismatch exp allowed=%0b status=%0b held=%0d, got %0b %0b %0d",
                       $realtime, want.allowed, want.status, want.entries_held,
                       out_data_i.allowed, out_data_i.status, out_data_i.entries_held);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        verdict_q.push_back(whitelist_verdict(in_data_i));
      pending_o = verdict_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ipwl_pkg::*;

  localparam int NumItems   = 700;
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 80;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        mismatches;
  int        pending;
  int        idle_cycles = 0;

  // Stimulus-side view of the table, used to aim check addresses at entries
  logic [AddrW-1:0] aim_net  [MaxEntries];
  int               aim_plen [MaxEntries];
  int               aim_cnt  = 0;
  int               sent_cnt = 0;

  always #5 clk = ~clk;

  ipv4_prefix_whitelist_match dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ipwl_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one transaction; called and returns at a falling edge
  task automatic send(input func_e fn, input logic [AddrW-1:0] addr,
                      input logic [PrefixW-1:0] plen);
    int gap;
    in_item_t it;
    it.func       = fn;
    it.address    = addr;
    it.prefix_len = plen;
    gap = (sent_cnt >= 300 && sent_cnt < 400) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent_cnt++;
    if (fn == FnAppend && aim_cnt < MaxEntries) begin
      aim_net[aim_cnt]  = addr;
      aim_plen[aim_cnt] = (plen > 32) ? 32 : int'(plen);
      aim_cnt++;
    end else if (fn == FnClear) begin
      aim_cnt = 0;
    end
    @(negedge clk);
  endtask

  // Result side: random stalls, a quiet stretch and two long hold-offs
  initial begin
    int n_res, hold;
    n_res = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (n_res == 40 || n_res == 500) hold = HoldCycles;
      else if (n_res >= 300 && n_res < 400) hold = 0;
      else hold = $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      n_res++;
    end
  end

  // Stimulus and verdict
  initial begin
    int n_app, n_chk, k, p;
    logic [AddrW-1:0] addr, m;
    func_e fn;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list allows everything; unused code is a no-op
    send(FnCheck, 32'h0000_0000, 6'd0);
    send(FnCheck, 32'hFFFF_FFFF, 6'h3F);
    send(FnNop,   32'hFFFF_FFFF, 6'h3F);
    // /24 with host bits set, hits and misses
    send(FnAppend, 32'hC0A8_0117, 6'd24);
    send(FnCheck,  32'hC0A8_01FF, 6'd0);
    send(FnCheck,  32'hC0A8_02FF, 6'd0);
    send(FnCheck,  32'h40A8_0101, 6'd0);
    // Prefix above 32 saturates to an exact host match
    send(FnAppend, 32'h0102_0304, 6'h3F);
    send(FnCheck,  32'h0102_0304, 6'd0);
    send(FnCheck,  32'h0102_0305, 6'd0);
    send(FnAppend, 32'h0A00_0000, 6'd33);
    send(FnAppend, 32'h8000_0000, 6'd1);
    send(FnCheck,  32'hFFFF_FFFE, 6'd0);
    send(FnAppend, 32'hFFFF_FFFF, 6'd32);
    send(FnAppend, 32'hAC10_0000, 6'd12);
    send(FnAppend, 32'h0000_0000, 6'd31);
    send(FnAppend, 32'h1234_5678, 6'd8);
    // Table full: append ignored
    send(FnAppend, 32'h5555_5555, 6'd16);
    send(FnCheck,  32'h7F00_0001, 6'd0);
    send(FnCheck,  32'h0000_0001, 6'd0);
    send(FnClear,  32'hFFFF_FFFF, 6'h3F);
    send(FnCheck,  32'h7F00_0001, 6'd0);
    // Prefix 0 matches any address
    send(FnAppend, 32'hDEAD_BEEF, 6'd0);
    send(FnCheck,  32'h1234_5678, 6'd0);
    send(FnClear,  32'h0000_0000, 6'd0);

    // Random episodes: optional clear, a burst of appends, then aimed checks
    while (sent_cnt < NumItems) begin
      if ($urandom_range(0, 3) == 0) send(FnClear, $urandom, 6'($urandom));
      n_app = $urandom_range(0, 10);
      repeat (n_app) begin
        send(FnAppend, $urandom,
             ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32)));
      end
      n_chk = $urandom_range(2, 10);
      repeat (n_chk) begin
        addr = $urandom;
        if (aim_cnt > 0 && $urandom_range(0, 2) != 0) begin
          k = $urandom_range(0, aim_cnt - 1);
          p = aim_plen[k];
          m = (p == 0) ? '0 : ({AddrW{1'b1}} << (AddrW - p));
          addr = (aim_net[k] & m) | (addr & ~m);
          // near miss: flip the last bit inside the prefix
          if (p > 0 && $urandom_range(0, 1) == 1) addr = addr ^ (32'h1 << (AddrW - p));
        end
        fn = ($urandom_range(0, 19) == 0) ? func_e'(2'($urandom_range(0, 3))) : FnCheck;
        send(fn, addr, 6'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for the longest check walk
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
